>>> design/prt3d_pkg.sv
// shared types, constants and trig helpers for the 3d point rotate/translate block
package prt3d_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TABLE_FRAC     = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int ANGLE_W        = 9;
    localparam int FULL_TURN      = 360;
    localparam int QUARTER_TURN   = 90;
    localparam int ENTRY_W        = 17;
    localparam int QIDX_W         = 7;

    localparam int SH_UP     = (TRIG_FRAC_BITS >= TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
    localparam int SH_DN     = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
    localparam int ROUND_ADD = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;

    localparam int OP_W         = 2;
    localparam int REG_IDX_W    = 2;
    localparam int CFG_DATA_W   = (COORD_WIDTH > ANGLE_W) ? COORD_WIDTH : ANGLE_W;
    localparam int IN_FIELDS_W  = OP_W + 3 * COORD_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * COORD_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ROT_Y = 2'd0,
        OP_ROT_X = 2'd1,
        OP_SHIFT = 2'd2,
        OP_PASS  = 2'd3
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ANGLE   = 2'd0,
        REG_SHIFT_X = 2'd1,
        REG_SHIFT_Y = 2'd2,
        REG_SHIFT_Z = 2'd3
    } reg_idx_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]      trig_t;

    // the last declared field (op) sits in the lowest bits
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
        op_t    op;
    } item_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } result_t;

    typedef struct packed {
        trig_t  sin_val;
        trig_t  cos_val;
        coord_t shift_x;
        coord_t shift_y;
        coord_t shift_z;
    } xform_cfg_t;

    // round(2^15 * sin(d)), d = 0..90
    localparam logic [ENTRY_W-1:0] QSINE [0:QUARTER_TURN] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    localparam trig_t TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

    function automatic trig_t scale_entry(logic [ENTRY_W-1:0] e);
        logic [ENTRY_W:0] rounded;
        trig_t            res;
        rounded = {1'b0, e} + (ENTRY_W + 1)'(ROUND_ADD);
        if (TRIG_FRAC_BITS >= TABLE_FRAC)
        begin
            res = TRIG_W'(e) << SH_UP;
        end
        else
        begin
            res = TRIG_W'(rounded >> SH_DN);
        end
        return res;
    endfunction

    function automatic logic [ANGLE_W-1:0] reduce_angle(logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] res;
        if (a >= ANGLE_W'(FULL_TURN))
        begin
            res = a - ANGLE_W'(FULL_TURN);
        end
        else
        begin
            res = a;
        end
        return res;
    endfunction

    // a is already below a full turn
    function automatic trig_t fixed_sine(logic [ANGLE_W-1:0] a);
        logic [1:0]         q;
        logic [ANGLE_W-1:0] r;
        logic [QIDX_W-1:0]  idx;
        trig_t              mag;
        if (a >= ANGLE_W'(3 * QUARTER_TURN))
        begin
            q = 2'd3;
            r = a - ANGLE_W'(3 * QUARTER_TURN);
        end
        else if (a >= ANGLE_W'(2 * QUARTER_TURN))
        begin
            q = 2'd2;
            r = a - ANGLE_W'(2 * QUARTER_TURN);
        end
        else if (a >= ANGLE_W'(QUARTER_TURN))
        begin
            q = 2'd1;
            r = a - ANGLE_W'(QUARTER_TURN);
        end
        else
        begin
            q = 2'd0;
            r = a;
        end
        idx = q[0] ? (QIDX_W'(QUARTER_TURN) - r[QIDX_W-1:0]) : r[QIDX_W-1:0];
        mag = scale_entry(QSINE[idx]);
        return q[1] ? -mag : mag;
    endfunction

    function automatic trig_t fixed_cosine(logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] b;
        b = reduce_angle(a + ANGLE_W'(QUARTER_TURN));
        return fixed_sine(b);
    endfunction

endpackage

>>> design/prt3d_cfg.sv
// configuration registers with sine and cosine looked up on the angle write
module prt3d_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  prt3d_pkg::reg_idx_t                 cfg_addr,
    input  logic [prt3d_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output prt3d_pkg::xform_cfg_t               cfg
);
    import prt3d_pkg::*;

    trig_t              sin_reg, sin_next;
    trig_t              cos_reg, cos_next;
    coord_t             shift_x_reg, shift_x_next;
    coord_t             shift_y_reg, shift_y_next;
    coord_t             shift_z_reg, shift_z_next;
    logic [ANGLE_W-1:0] angle_in;

    assign angle_in = reduce_angle(cfg_wdata[ANGLE_W-1:0]);

    always_comb
    begin
        sin_next     = sin_reg;
        cos_next     = cos_reg;
        shift_x_next = shift_x_reg;
        shift_y_next = shift_y_reg;
        shift_z_next = shift_z_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ANGLE:
                begin
                    sin_next = fixed_sine(angle_in);
                    cos_next = fixed_cosine(angle_in);
                end
                REG_SHIFT_X: shift_x_next = cfg_wdata[COORD_WIDTH-1:0];
                REG_SHIFT_Y: shift_y_next = cfg_wdata[COORD_WIDTH-1:0];
                REG_SHIFT_Z: shift_z_next = cfg_wdata[COORD_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg     <= '0;
            cos_reg     <= TRIG_ONE;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
        end
        else
        begin
            sin_reg     <= sin_next;
            cos_reg     <= cos_next;
            shift_x_reg <= shift_x_next;
            shift_y_reg <= shift_y_next;
            shift_z_reg <= shift_z_next;
        end
    end

    assign cfg.sin_val = sin_reg;
    assign cfg.cos_val = cos_reg;
    assign cfg.shift_x = shift_x_reg;
    assign cfg.shift_y = shift_y_reg;
    assign cfg.shift_z = shift_z_reg;

endmodule

>>> design/prt3d_xform.sv
// rotation and translation datapath between the input and result registers
module prt3d_xform (
    input  prt3d_pkg::item_t        item,
    input  prt3d_pkg::xform_cfg_t   cfg,
    output prt3d_pkg::result_t      res
);
    import prt3d_pkg::*;

    localparam int PROD_W = COORD_WIDTH + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ADD_W  = COORD_WIDTH + 1;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [ADD_W-1:0]  add_t;

    localparam sum_t SUM_MAX  = SUM_W'((1 << (COORD_WIDTH - 1)) - 1);
    localparam sum_t SUM_MIN  = -SUM_MAX - SUM_W'(1);
    localparam sum_t FRAC_ADJ = SUM_W'((1 << TRIG_FRAC_BITS) - 1);
    localparam add_t ADD_MAX  = ADD_W'((1 << (COORD_WIDTH - 1)) - 1);
    localparam add_t ADD_MIN  = -ADD_MAX - ADD_W'(1);

    // truncate toward zero, then clamp to the coordinate range
    function automatic coord_t to_coord(sum_t s);
        sum_t adj;
        sum_t q;
        coord_t r;
        adj = s + (s[SUM_W-1] ? FRAC_ADJ : '0);
        q   = adj >>> TRIG_FRAC_BITS;
        if (q > SUM_MAX)
        begin
            r = SUM_MAX[COORD_WIDTH-1:0];
        end
        else if (q < SUM_MIN)
        begin
            r = SUM_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            r = q[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic coord_t sat_add(coord_t a, coord_t b);
        add_t s;
        coord_t r;
        s = ADD_W'(a) + ADD_W'(b);
        if (s > ADD_MAX)
        begin
            r = ADD_MAX[COORD_WIDTH-1:0];
        end
        else if (s < ADD_MIN)
        begin
            r = ADD_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            r = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    prod_t a_cos, b_sin, b_cos, a_sin;
    coord_t a_val, b_val;
    coord_t rot_a, rot_b;

    // the rotating pair: (x, z) about y, (y, z) about x
    assign a_val = (item.op == OP_ROT_X) ? item.y : item.x;
    assign b_val = item.z;

    assign a_cos = PROD_W'(a_val) * PROD_W'(cfg.cos_val);
    assign a_sin = PROD_W'(a_val) * PROD_W'(cfg.sin_val);
    assign b_cos = PROD_W'(b_val) * PROD_W'(cfg.cos_val);
    assign b_sin = PROD_W'(b_val) * PROD_W'(cfg.sin_val);

    always_comb
    begin
        rot_a = '0;
        rot_b = '0;
        res.x = item.x;
        res.y = item.y;
        res.z = item.z;
        unique case (item.op)
            OP_ROT_Y:
            begin
                rot_a = to_coord(SUM_W'(a_cos) + SUM_W'(b_sin));
                rot_b = to_coord(SUM_W'(b_cos) - SUM_W'(a_sin));
                res.x = rot_a;
                res.z = rot_b;
            end
            OP_ROT_X:
            begin
                rot_a = to_coord(SUM_W'(a_cos) - SUM_W'(b_sin));
                rot_b = to_coord(SUM_W'(a_sin) + SUM_W'(b_cos));
                res.y = rot_a;
                res.z = rot_b;
            end
            OP_SHIFT:
            begin
                res.x = sat_add(item.x, cfg.shift_x);
                res.y = sat_add(item.y, cfg.shift_y);
                res.z = sat_add(item.z, cfg.shift_z);
            end
            OP_PASS:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> design/point_rotate_translate_3d_top.sv
// top level of the 3d point rotate/translate block
//
// one point in on the s_ side, one transformed point out on the m_ side per beat
// s_tdata carries the operation and the point, m_tdata the transformed point
// operation 0 rotates about y, 1 about x, 2 adds the shift registers, 3 passes through
// the config port writes angle_deg, shift_x, shift_y, shift_z at indexes 0 to 3;
// sine and cosine are looked up when the angle is written
// a taken beat goes from the input register to the result register that drives m_tdata
// throughput: one point per cycle while m_tready is high, set by the input register and
// result register each holding one point, with the four products worked in parallel
// between them; when m_tready is low the result register holds and the input register
// still takes one more beat; s_tready falls only when both are full
// reset clears both valid flags, the angle to 0 and the shifts to 0
module point_rotate_translate_3d_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prt3d_pkg::IN_TDATA_W-1:0]    s_tdata,   // operation, in_x, in_y, in_z
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prt3d_pkg::OUT_TDATA_W-1:0]   m_tdata,   // out_x, out_y, out_z
    input  logic                                cfg_wr_en,
    input  prt3d_pkg::reg_idx_t                 cfg_addr,
    input  logic [prt3d_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import prt3d_pkg::*;

    xform_cfg_t cfg;
    item_t      in_item_reg, in_item_next;
    logic       in_valid_reg, in_valid_next;
    result_t    out_data_reg, out_data_next;
    logic       out_valid_reg, out_valid_next;
    result_t    res;
    logic       out_load;
    logic       in_load;

    prt3d_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    prt3d_xform u_xform (
        .item (in_item_reg),
        .cfg  (cfg),
        .res  (res)
    );

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next   = in_load ? item_t'(s_tdata[IN_FIELDS_W-1:0]) : in_item_reg;
        in_valid_next  = in_load || (in_valid_reg && !out_load);
        out_data_next  = (out_load && in_valid_reg) ? res : out_data_reg;
        out_valid_next = out_load ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

>>> design/prt3d_checker.sv
// port-level checks for the 3d point rotate/translate block, bound to the top level
module prt3d_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [prt3d_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // an empty result side never holds off the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // a taken beat moves from the input register to the output when the receiver is ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted beat did not reach the output");

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind point_rotate_translate_3d_top prt3d_checker u_prt3d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/testbench.sv
// testbench for the 3d point rotate/translate block: directed table, then random phases
`timescale 1ns / 1ps

module testbench;
    import prt3d_pkg::*;

    localparam longint UNIT_Q15  = 64'sd32768;
    localparam longint COORD_MAX = 64'sd32767;
    localparam longint COORD_MIN = -64'sd32768;

    localparam int SINE_Q15 [0:90] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    typedef struct {
        bit                    is_write;
        reg_idx_t              idx;
        logic [CFG_DATA_W-1:0] val;
        item_t                 pt;
        bit                    known;
        result_t               res;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    reg_idx_t               cfg_addr = REG_ANGLE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic [ANGLE_W-1:0] cur_angle = '0;
    coord_t             cur_shift_x = '0;
    coord_t             cur_shift_y = '0;
    coord_t             cur_shift_z = '0;

    result_t  pending_points [$];
    dir_row_t dir_rows [$];
    int       points_checked = 0;
    int       err_count = 0;
    bit       calm = 1'b0;

    point_rotate_translate_3d_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic longint sine_q15(input int a);
        int     q;
        int     r;
        longint mag;
        q = a / 90;
        r = a % 90;
        mag = (q % 2 == 1) ? SINE_Q15[90 - r] : SINE_Q15[r];
        return (q >= 2) ? -mag : mag;
    endfunction

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_MAX)
        begin
            return coord_t'(COORD_MAX);
        end
        if (v < COORD_MIN)
        begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

    function automatic result_t transform_point(input item_t it);
        int      a;
        longint  x;
        longint  y;
        longint  z;
        longint  s;
        longint  c;
        result_t r;
        a = cur_angle;
        if (a >= 360)
        begin
            a = a - 360;
        end
        s = sine_q15(a);
        c = sine_q15((a + 90) % 360);
        x = it.x;
        y = it.y;
        z = it.z;
        r.x = it.x;
        r.y = it.y;
        r.z = it.z;
        case (it.op)
            OP_ROT_Y:
            begin
                r.x = clamp_coord((x * c + z * s) / UNIT_Q15);
                r.z = clamp_coord((z * c - x * s) / UNIT_Q15);
            end
            OP_ROT_X:
            begin
                r.y = clamp_coord((y * c - z * s) / UNIT_Q15);
                r.z = clamp_coord((y * s + z * c) / UNIT_Q15);
            end
            OP_SHIFT:
            begin
                r.x = clamp_coord(x + longint'(cur_shift_x));
                r.y = clamp_coord(y + longint'(cur_shift_y));
                r.z = clamp_coord(z + longint'(cur_shift_z));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic coord_t pick_coord();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return coord_t'(COORD_MAX);
            1: return coord_t'(COORD_MIN);
            2: return coord_t'($urandom_range(0, 6) - 3);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic op_t pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)
        begin
            return OP_ROT_Y;
        end
        if (r < 12)
        begin
            return OP_ROT_X;
        end
        if (r < 18)
        begin
            return OP_SHIFT;
        end
        return OP_PASS;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_shift();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_angle();
        int a;
        case ($urandom_range(0, 5))
            0: a = 90 * $urandom_range(0, 3);
            1: a = 359;
            2: a = $urandom_range(360, 511);
            default: a = $urandom_range(0, 359);
        endcase
        return {7'($urandom()), 9'(a)};
    endfunction

    function automatic dir_row_t cfg_row(input reg_idx_t idx, input int val);
        dir_row_t row;
        row = '{idx: REG_ANGLE, default: '0};
        row.is_write = 1'b1;
        row.idx = idx;
        row.val = CFG_DATA_W'(val);
        return row;
    endfunction

    function automatic dir_row_t pt_row(input op_t op, input int x, input int y, input int z,
                                        input bit known, input int ex, input int ey,
                                        input int ez);
        dir_row_t row;
        row = '{idx: REG_ANGLE, default: '0};
        row.pt.op = op;
        row.pt.x = coord_t'(x);
        row.pt.y = coord_t'(y);
        row.pt.z = coord_t'(z);
        row.known = known;
        row.res.x = coord_t'(ex);
        row.res.y = coord_t'(ey);
        row.res.z = coord_t'(ez);
        return row;
    endfunction

    task automatic send_point(input item_t it, input result_t want);
        int gap;
        s_tdata <= IN_TDATA_W'(it);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_points.push_back(want);
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ANGLE:   cur_angle = val[ANGLE_W-1:0];
            REG_SHIFT_X: cur_shift_x = coord_t'(val);
            REG_SHIFT_Y: cur_shift_y = coord_t'(val);
            REG_SHIFT_Z: cur_shift_z = coord_t'(val);
            default:
            begin
            end
        endcase
    endtask

    initial
    begin : result_sink
        int      stall_left;
        bit      held_long;
        bit      ready_now;
        result_t got;
        result_t want;
        stall_left = 0;
        held_long = 1'b0;
        forever
        begin
            ready_now = 1'b1;
            if (stall_left > 0)
            begin
                ready_now = 1'b0;
                stall_left--;
            end
            else if (!held_long && points_checked >= 300 && s_tvalid)
            begin
                // long hold-off so the block fills and stalls its input
                held_long = 1'b1;
                stall_left = 79;
                ready_now = 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 15)
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    ready_now = 1'b0;
                    stall_left--;
                end
            end
            m_tready <= ready_now;
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (pending_points.size() == 0)
                begin
                    $error("result beat with no point pending: %h", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    points_checked++;
                    if (got.x !== want.x)
                    begin
                        $error("out_x mismatch: expected %0d, got %0d", want.x, got.x);
                        err_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("out_y mismatch: expected %0d, got %0d", want.y, got.y);
                        err_count++;
                    end
                    if (got.z !== want.z)
                    begin
                        $error("out_z mismatch: expected %0d, got %0d", want.z, got.z);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int       waited;
        dir_row_t row;
        item_t    it;
        // after reset: identity rotation, zero shifts
        dir_rows.push_back(pt_row(OP_ROT_Y, 100, -200, 300, 1, 100, -200, 300));
        dir_rows.push_back(pt_row(OP_ROT_X, 32767, -32768, -32768, 1, 32767, -32768, -32768));
        dir_rows.push_back(pt_row(OP_SHIFT, -32768, 32767, 0, 1, -32768, 32767, 0));
        dir_rows.push_back(pt_row(OP_PASS, 1234, -5, 32767, 1, 1234, -5, 32767));
        dir_rows.push_back(cfg_row(REG_ANGLE, 90));
        dir_rows.push_back(pt_row(OP_ROT_Y, 1000, 7, 2000, 1, 2000, 7, -1000));
        dir_rows.push_back(pt_row(OP_ROT_X, 5, -32768, 32767, 1, 5, -32767, -32768));
        // rotation overflow
        dir_rows.push_back(pt_row(OP_ROT_Y, -32768, 0, -32768, 1, -32768, 0, 32767));
        dir_rows.push_back(cfg_row(REG_ANGLE, 45));
        dir_rows.push_back(pt_row(OP_ROT_Y, 32767, 1, 32767, 0, 0, 0, 0));
        dir_rows.push_back(pt_row(OP_ROT_X, -32768, -32768, 32767, 0, 0, 0, 0));
        // angle above a full turn
        dir_rows.push_back(cfg_row(REG_ANGLE, 511));
        dir_rows.push_back(pt_row(OP_ROT_Y, 12345, -23456, 31000, 0, 0, 0, 0));
        dir_rows.push_back(pt_row(OP_ROT_X, -1, -32768, 32767, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE, 359));
        dir_rows.push_back(pt_row(OP_ROT_Y, 32767, 32767, -32768, 0, 0, 0, 0));
        dir_rows.push_back(pt_row(OP_ROT_X, -1, 1, -1, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE, 360));
        dir_rows.push_back(pt_row(OP_ROT_X, -3, 4, -5, 1, -3, 4, -5));
        // translation overflow
        dir_rows.push_back(cfg_row(REG_SHIFT_X, 32767));
        dir_rows.push_back(cfg_row(REG_SHIFT_Y, -32768));
        dir_rows.push_back(cfg_row(REG_SHIFT_Z, -1));
        dir_rows.push_back(pt_row(OP_SHIFT, 32767, -32768, 0, 1, 32767, -32768, -1));
        dir_rows.push_back(pt_row(OP_SHIFT, -32768, 32767, 1, 1, -1, -1, 0));
        dir_rows.push_back(pt_row(OP_PASS, -32768, 32767, -1, 1, -32768, 32767, -1));
        dir_rows.push_back(cfg_row(REG_ANGLE, 270));
        dir_rows.push_back(pt_row(OP_ROT_Y, 100, 0, 0, 1, 0, 0, 100));
        dir_rows.push_back(pt_row(OP_ROT_X, 1, -1, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE, 180));
        dir_rows.push_back(pt_row(OP_ROT_Y, -32768, 0, -32768, 1, 32767, 0, 32767));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_write)
            begin
                write_reg(row.idx, row.val);
            end
            else
            begin
                send_point(row.pt, row.known ? row.res : transform_point(row.pt));
            end
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            write_reg(REG_ANGLE, pick_angle());
            write_reg(REG_SHIFT_X, pick_shift());
            write_reg(REG_SHIFT_Y, pick_shift());
            write_reg(REG_SHIFT_Z, pick_shift());
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
            begin
                it.op = pick_op();
                it.x = pick_coord();
                it.y = pick_coord();
                it.z = pick_coord();
                send_point(it, transform_point(it));
            end
            calm = 1'b0;
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_points.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_points.size() != 0)
        begin
            $error("%0d expected points never came out", pending_points.size());
            err_count++;
        end
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
